FILE: hw/rtl/sparse_table_range_minimum_macros.svh
// Assertion macros shared by the sparse-table range-minimum RTL.
// Expects clk and rst_n in the scope of use; empty bodies under SYNTHESIS.
`ifndef SPARSE_TABLE_RANGE_MINIMUM_MACROS_SVH
`define SPARSE_TABLE_RANGE_MINIMUM_MACROS_SVH

`ifndef SYNTHESIS

`define STRM_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`define STRM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

`define STRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define STRM_ASSERT_NEVER(label, cond)
`define STRM_ASSERT_IMPLIES(label, ante, cons)
`define STRM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/strm_pkg.sv
// Shared constants for the sparse-table range-minimum engine.
// No dependencies.
`timescale 1ns / 1ps

package strm_pkg;

    localparam int MAX_LEN_DEF    = 1024;
    localparam int LOG_LEVELS_DEF = 11;
    localparam int KEY_BITS_DEF   = 16;

    // fixed port widths
    localparam int CMD_BITS      = 2;
    localparam int KEY_PORT_BITS = 16;
    localparam int VAL_BITS      = 16;
    localparam int POS_BITS      = 10;
    localparam int STAT_BITS     = 2;

    localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd2;

endpackage

FILE: hw/rtl/sparse_table_range_minimum.sv
// Sparse-table range-minimum engine over (key, value) pairs: top level.
// Depends on strm_pkg, strm_table and sparse_table_range_minimum_macros.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in      | into blk  | in_valid/in_stall  | cmd, key_in, value_in, pos_a, pos_b
//   out     | from blk  | out_valid/out_stall| min_key, min_value, status
//
// One request at a time. Append: level 0 written directly, then one level per cycle,
// each a read-min-write through the table's read port A.
// Query: order/check, log2, two table reads, compare, hand-off.
// Clear, unused command, full store, out-of-range query: check, then hand-off.
// Reset clears the pair count and the control; the table is not cleared.
// A result waits in the output register while the next request is taken in;
// out_stall only holds the engine once a second result is ready.
`timescale 1ns / 1ps

`include "sparse_table_range_minimum_macros.svh"

module sparse_table_range_minimum #(
    parameter int MAX_LEN    = strm_pkg::MAX_LEN_DEF,
    parameter int LOG_LEVELS = strm_pkg::LOG_LEVELS_DEF,
    parameter int KEY_BITS   = strm_pkg::KEY_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [strm_pkg::CMD_BITS-1:0]       cmd,
    input  logic [strm_pkg::KEY_PORT_BITS-1:0]  key_in,
    input  logic [strm_pkg::VAL_BITS-1:0]       value_in,
    input  logic [strm_pkg::POS_BITS-1:0]       pos_a,
    input  logic [strm_pkg::POS_BITS-1:0]       pos_b,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [strm_pkg::KEY_PORT_BITS-1:0]  min_key,
    output logic [strm_pkg::VAL_BITS-1:0]       min_value,
    output logic [strm_pkg::STAT_BITS-1:0]      status
);

    localparam int KPB    = strm_pkg::KEY_PORT_BITS;
    localparam int VB     = strm_pkg::VAL_BITS;
    localparam int PB     = strm_pkg::POS_BITS;
    localparam int SB     = strm_pkg::STAT_BITS;
    localparam int KW     = (KEY_BITS < KPB) ? KEY_BITS : KPB;
    localparam int PW     = KW + VB;
    localparam int POS_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int LVL_W  = $clog2(LOG_LEVELS);
    localparam int WW     = (CNT_W > PB) ? CNT_W : PB;
    localparam int ADDR_W = LVL_W + POS_W;
    localparam int DEPTH  = LOG_LEVELS * (1 << POS_W);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_A_L0   = 7'b0000010,
        ST_A_LVL  = 7'b0000100,
        ST_Q_LOG  = 7'b0001000,
        ST_Q_READ = 7'b0010000,
        ST_Q_WAIT = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    // floor(log2(n)), clamped to the top level
    function automatic logic [LVL_W-1:0] lvl_of_len(input logic [CNT_W-1:0] n);
        int k;
        k = 0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (n[i])
            begin
                k = i;
            end
        end
        if (k > LOG_LEVELS - 1)
        begin
            k = LOG_LEVELS - 1;
        end
        return LVL_W'(k);
    endfunction

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  p1_reg, p1_next;        // append position + 1
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [POS_W-1:0]  pos_reg, pos_next;      // start of entry being written / query left
    logic [POS_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [PW-1:0]     pair_reg, pair_next;    // running minimum of the append
    logic [KW-1:0]     res_key_reg, res_key_next;
    logic [VB-1:0]     res_value_reg, res_value_next;
    logic [SB-1:0]     res_status_reg, res_status_next;

    logic              out_valid_reg, out_valid_next;
    logic [KPB-1:0]    min_key_reg, min_key_next;
    logic [VB-1:0]     min_value_reg, min_value_next;
    logic [SB-1:0]     status_reg, status_next;

    logic              tbl_we;
    logic [ADDR_W-1:0] tbl_waddr;
    logic [PW-1:0]     tbl_wdata;
    logic [ADDR_W-1:0] tbl_raddr_a;
    logic [ADDR_W-1:0] tbl_raddr_b;
    logic [PW-1:0]     tbl_rdata_a;
    logic [PW-1:0]     tbl_rdata_b;
    logic              rd_a_en;

    logic              in_take;
    logic [WW-1:0]     lw, rw;
    logic [LVL_W:0]    lvl_nx;
    logic              more_lvls;
    logic [CNT_W-1:0]  nx_start;
    logic [PW-1:0]     lvl_min;
    logic [CNT_W-1:0]  q_start;
    logic [POS_W-1:0]  q_pos_b;
    logic [PW-1:0]     q_min;

    strm_table #(
        .DATA_W (PW),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .we      (tbl_we),
        .waddr   (tbl_waddr),
        .wdata   (tbl_wdata),
        .raddr_a (tbl_raddr_a),
        .raddr_b (tbl_raddr_b),
        .rdata_a (tbl_rdata_a),
        .rdata_b (tbl_rdata_b)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    // ordered query ends
    assign lw = (pos_a < pos_b) ? WW'(pos_a) : WW'(pos_b);
    assign rw = (pos_a < pos_b) ? WW'(pos_b) : WW'(pos_a);

    // next level of an append: entry [p+1-2^j .. p] exists when p+1 >= 2^j
    assign lvl_nx    = {1'b0, lvl_reg} + (LVL_W + 1)'(1);
    assign more_lvls = (lvl_nx < (LVL_W + 1)'(LOG_LEVELS)) && ((p1_reg >> lvl_nx) != '0);
    assign nx_start  = p1_reg - (CNT_W'(1) << lvl_nx);
    assign lvl_min   = (tbl_rdata_a < pair_reg) ? tbl_rdata_a : pair_reg;

    // second query entry starts at r+1-2^k, never left of l
    assign q_start = CNT_W'(r_reg) + CNT_W'(1) - (CNT_W'(1) << lvl_reg);
    assign q_pos_b = (q_start < CNT_W'(pos_reg)) ? pos_reg : q_start[POS_W-1:0];
    assign q_min   = (tbl_rdata_a < tbl_rdata_b) ? tbl_rdata_a : tbl_rdata_b;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        p1_next         = p1_reg;
        lvl_next        = lvl_reg;
        pos_next        = pos_reg;
        r_next          = r_reg;
        len_next        = len_reg;
        pair_next       = pair_reg;
        res_key_next    = res_key_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        min_key_next    = min_key_reg;
        min_value_next  = min_value_reg;
        status_next     = status_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = {lvl_reg, pos_reg};
        tbl_wdata       = pair_reg;
        tbl_raddr_a     = {LVL_W'(lvl_nx), nx_start[POS_W-1:0]};
        tbl_raddr_b     = {lvl_reg, q_pos_b};
        rd_a_en         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    res_key_next    = '0;
                    res_value_next  = '0;
                    res_status_next = strm_pkg::STAT_OK;
                    state_next      = ST_DONE;
                    unique case (cmd)
                        strm_pkg::CMD_APPEND:
                        begin
                            if (count_reg >= CNT_W'(MAX_LEN))
                            begin
                                res_status_next = strm_pkg::STAT_FULL;
                            end
                            else
                            begin
                                pair_next  = {key_in[KW-1:0], value_in};
                                lvl_next   = '0;
                                pos_next   = count_reg[POS_W-1:0];
                                p1_next    = count_reg + CNT_W'(1);
                                count_next = count_reg + CNT_W'(1);
                                state_next = ST_A_L0;
                            end
                        end
                        strm_pkg::CMD_QUERY:
                        begin
                            if (rw >= WW'(count_reg))
                            begin
                                res_status_next = strm_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                pos_next   = lw[POS_W-1:0];
                                r_next     = rw[POS_W-1:0];
                                len_next   = CNT_W'(rw - lw + WW'(1));
                                state_next = ST_Q_LOG;
                            end
                        end
                        strm_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // unused command: plain ok result
                        end
                    endcase
                end
            end
            ST_A_L0, ST_A_LVL:
            begin
                tbl_we    = 1'b1;
                tbl_wdata = (state_reg == ST_A_L0) ? pair_reg : lvl_min;
                pair_next = (state_reg == ST_A_L0) ? pair_reg : lvl_min;
                if (more_lvls)
                begin
                    // fetch the older half of the next level; the newer half is pair_reg
                    rd_a_en    = 1'b1;
                    tbl_raddr_a = {lvl_reg, nx_start[POS_W-1:0]};
                    lvl_next   = LVL_W'(lvl_nx);
                    pos_next   = nx_start[POS_W-1:0];
                    state_next = ST_A_LVL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_Q_LOG:
            begin
                lvl_next   = lvl_of_len(len_reg);
                state_next = ST_Q_READ;
            end
            ST_Q_READ:
            begin
                rd_a_en     = 1'b1;
                tbl_raddr_a = {lvl_reg, pos_reg};
                tbl_raddr_b = {lvl_reg, q_pos_b};
                state_next  = ST_Q_WAIT;
            end
            ST_Q_WAIT:
            begin
                res_key_next   = q_min[PW-1:VB];
                res_value_next = q_min[VB-1:0];
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    min_key_next   = KPB'(res_key_reg);
                    min_value_next = res_value_reg;
                    status_next    = res_status_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg         <= p1_next;
        lvl_reg        <= lvl_next;
        pos_reg        <= pos_next;
        r_reg          <= r_next;
        len_reg        <= len_next;
        pair_reg       <= pair_next;
        res_key_reg    <= res_key_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        min_key_reg    <= min_key_next;
        min_value_reg  <= min_value_next;
        status_reg     <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign min_key   = min_key_reg;
    assign min_value = min_value_reg;
    assign status    = status_reg;

    `STRM_ASSERT_NEVER(a_no_rw_clash, tbl_we && rd_a_en && (tbl_waddr == tbl_raddr_a))
    `STRM_ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(MAX_LEN))
    `STRM_ASSERT_NEXT(a_take_leaves_idle, in_take, state_reg != ST_IDLE)
    `STRM_ASSERT_IMPLIES(a_out_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE))
    `STRM_ASSERT_NEXT(a_append_grows, in_take && (cmd == strm_pkg::CMD_APPEND) && (count_reg < CNT_W'(MAX_LEN)), count_reg == $past(count_reg) + CNT_W'(1))

endmodule

FILE: hw/rtl/strm_table.sv
// Level table storage: one write port, two read ports, registered read data.
// Uses no package items.
`timescale 1ns / 1ps

module strm_table #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
